[hw/rtl/sicxe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sicxe_pkg
// Shared types, codes and helpers for the SIC/XE instruction step block.
// ----------------------------------------------------------------------------
package sicxe_pkg;

    localparam int ADDR_BITS_DEF = 20;
    localparam int WORD_W        = 24;

    // request modes
    localparam logic [1:0] MODE_WR_MEM = 2'd0;
    localparam logic [1:0] MODE_WR_REG = 2'd1;
    localparam logic [1:0] MODE_EXEC   = 2'd2;

    // register numbers
    localparam logic [3:0] REG_A  = 4'd0;
    localparam logic [3:0] REG_X  = 4'd1;
    localparam logic [3:0] REG_L  = 4'd2;
    localparam logic [3:0] REG_B  = 4'd3;
    localparam logic [3:0] REG_S  = 4'd4;
    localparam logic [3:0] REG_T  = 4'd5;
    localparam logic [3:0] REG_PC = 4'd6;

    // condition codes
    localparam logic [1:0] CC_EQ = 2'd0;
    localparam logic [1:0] CC_LT = 2'd1;
    localparam logic [1:0] CC_GT = 2'd2;

    // configuration register indexes
    localparam logic CFG_PROG_START  = 1'b0;
    localparam logic CFG_PROG_LENGTH = 1'b1;

    // opcodes (top six bits of the first byte, low two bits zero)
    localparam logic [7:0] OP_CLEAR = 8'hB4;
    localparam logic [7:0] OP_COMPR = 8'hA0;
    localparam logic [7:0] OP_TIXR  = 8'hB8;
    localparam logic [7:0] OP_COMP  = 8'h28;
    localparam logic [7:0] OP_J     = 8'h3C;
    localparam logic [7:0] OP_JEQ   = 8'h30;
    localparam logic [7:0] OP_JLT   = 8'h38;
    localparam logic [7:0] OP_JSUB  = 8'h48;
    localparam logic [7:0] OP_RSUB  = 8'h4C;
    localparam logic [7:0] OP_LDA   = 8'h00;
    localparam logic [7:0] OP_LDB   = 8'h68;
    localparam logic [7:0] OP_LDT   = 8'h74;
    localparam logic [7:0] OP_LDCH  = 8'h50;
    localparam logic [7:0] OP_STA   = 8'h0C;
    localparam logic [7:0] OP_STCH  = 8'h54;
    localparam logic [7:0] OP_STL   = 8'h14;
    localparam logic [7:0] OP_STX   = 8'h10;
    localparam logic [7:0] OP_RD    = 8'hD8;
    localparam logic [7:0] OP_WD    = 8'hDC;
    localparam logic [7:0] OP_TD    = 8'hE0;

    typedef struct packed {
        logic [19:0] pc;
        logic [23:0] acc;
        logic [23:0] index_reg;
        logic [23:0] link_reg;
        logic [23:0] base_reg;
        logic [23:0] s_reg;
        logic [23:0] t_reg;
        logic [1:0]  cond;
        logic        halted;
        logic        illegal;
    } t_rsp;

    function automatic logic [1:0] compare(input logic [23:0] a, input logic [23:0] b);
        logic [1:0] c;
        if (a == b) begin
            c = CC_EQ;
        end else if (a < b) begin
            c = CC_LT;
        end else begin
            c = CC_GT;
        end
        return c;
    endfunction

    function automatic logic is_fmt3_op(input logic [7:0] op);
        logic ok;
        unique case (op)
            OP_COMP, OP_J, OP_JEQ, OP_JLT, OP_JSUB, OP_RSUB, OP_LDA, OP_LDB, OP_LDT,
            OP_LDCH, OP_STA, OP_STCH, OP_STL, OP_STX, OP_RD, OP_WD, OP_TD: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/sicxe_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sicxe_if
// Request, response and configuration channel interfaces.
// ----------------------------------------------------------------------------
interface sicxe_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [19:0] address;
    logic [23:0] data;
    logic [2:0]  reg_select;
    modport source (output valid, mode, address, data, reg_select, input ready);
    modport sink   (input valid, mode, address, data, reg_select, output ready);
endinterface

interface sicxe_rsp_if;
    logic        valid;
    logic        ready;
    logic [19:0] pc;
    logic [23:0] acc;
    logic [23:0] index_reg;
    logic [23:0] link_reg;
    logic [23:0] base_reg;
    logic [23:0] s_reg;
    logic [23:0] t_reg;
    logic [1:0]  cond;
    logic        halted;
    logic        illegal;
    modport source (output valid, pc, acc, index_reg, link_reg, base_reg, s_reg, t_reg,
                    cond, halted, illegal, input ready);
    modport sink   (input valid, pc, acc, index_reg, link_reg, base_reg, s_reg, t_reg,
                    cond, halted, illegal, output ready);
endinterface

interface sicxe_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [20:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/sicxe_instruction_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sicxe_instruction_step
// Memory and register writes are done on acceptance, then pass to the response stage;
//   an instruction makes 4 fetch reads, up to 3 indirect and 3 operand reads and up
//   to 3 store writes, all through the byte-wide memory ports.
// One request at a time: the next is taken from the cycle after the response is
//   loaded; a held response holds the input.
// Reset: registers, PC and condition code cleared, program start 0, length the
//   whole memory; memory is not cleared and holds nothing defined until written.
// ----------------------------------------------------------------------------
module sicxe_instruction_step #(
    parameter int ADDR_BITS = sicxe_pkg::ADDR_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    sicxe_req_if.sink      i_req,
    sicxe_rsp_if.source    o_rsp,
    sicxe_cfg_if.sink      i_cfg
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DECODE, S_ADDR, S_EXEC, S_STORE, S_FIN
    } t_state;

    // what a finished burst of byte reads feeds
    typedef enum logic [1:0] {P_FETCH, P_IND, P_OPND} t_phase;

    t_state             r_state;
    t_phase             r_phase;

    // architectural state
    logic [23:0]          r_a, r_x, r_l, r_b, r_s, r_t;
    logic [ADDR_BITS-1:0] r_pc;
    logic [1:0]           r_cc;
    logic [19:0]          r_start;
    logic [20:0]          r_len;

    // read burst engine
    logic [ADDR_BITS-1:0] r_rbase;
    logic [2:0]           r_rcnt, r_rgot, r_rlen;
    logic                 r_rpend;
    logic [31:0]          r_buf;

    // instruction in flight
    logic [31:0]          r_ins;
    logic [ADDR_BITS-1:0] r_ta, r_ea, r_next;
    logic [23:0]          r_wdata;
    logic [1:0]           r_wcnt, r_wlast;
    logic                 r_bad;

    sicxe_pkg::t_rsp      r_out;
    logic                 r_out_valid;

    logic                 mem_we, mem_re;
    logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
    logic [7:0]           mem_wdata, mem_rdata;

    sicxe_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    function automatic logic [23:0] getr(
        input logic [3:0] r, input logic [23:0] a, input logic [23:0] x,
        input logic [23:0] l, input logic [23:0] b, input logic [23:0] s,
        input logic [23:0] t);
        logic [23:0] v;
        priority case (r)
            sicxe_pkg::REG_A: v = a;
            sicxe_pkg::REG_X: v = x;
            sicxe_pkg::REG_L: v = l;
            sicxe_pkg::REG_B: v = b;
            sicxe_pkg::REG_S: v = s;
            sicxe_pkg::REG_T: v = t;
            default:          v = '0;
        endcase
        return v;
    endfunction

    logic req_fire, rsp_fire;
    assign req_fire = i_req.valid && i_req.ready;
    assign rsp_fire = r_out_valid && o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // halt test against the end of the program
    logic [21:0] prog_end;
    logic        at_end;
    assign prog_end = 22'(r_start) + 22'(r_len);
    assign at_end   = 22'(r_pc) >= prog_end;

    // fields of the fetched instruction (live in the buffer at decode time)
    logic [7:0]  d_op;
    logic [3:0]  d_r1, d_r2;
    logic [11:0] d_disp;
    logic [23:0] d_r1v, d_r2v, d_xinc;
    logic [ADDR_BITS-1:0] d_ta;
    assign d_op   = {r_buf[31:26], 2'b00};
    assign d_r1   = r_buf[23:20];
    assign d_r2   = r_buf[19:16];
    assign d_disp = r_buf[19:8];
    assign d_xinc = r_x + 24'd1;
    assign d_r1v  = getr(d_r1, r_a, r_x, r_l, r_b, r_s, r_t);
    assign d_r2v  = getr(d_r2, r_a, r_x, r_l, r_b, r_s, r_t);

    // target address: format 4, base-relative, PC-relative or direct, plus X
    always_comb begin
        logic [ADDR_BITS-1:0] base;
        if (r_buf[20]) begin
            base = ADDR_BITS'(r_buf[19:0]) + ADDR_BITS'(r_start);
        end else if (r_buf[22]) begin
            base = ADDR_BITS'(r_b) + ADDR_BITS'(d_disp);
        end else if (r_buf[21]) begin
            base = r_pc + ADDR_BITS'(3) + ADDR_BITS'(signed'(d_disp));
        end else begin
            base = ADDR_BITS'(d_disp);
        end
        d_ta = r_buf[23] ? base + ADDR_BITS'(r_x) : base;
    end

    // flags of the held instruction
    logic [7:0] h_op;
    logic       h_imm, h_ind, h_word_ld;
    logic [ADDR_BITS-1:0] h_ea;
    assign h_op  = {r_ins[31:26], 2'b00};
    assign h_imm = !r_ins[25];
    assign h_ind = r_ins[25] && !r_ins[24];
    assign h_ea  = h_ind ? r_buf[ADDR_BITS-1:0] : r_ta;
    assign h_word_ld = (h_op == sicxe_pkg::OP_COMP) || (h_op == sicxe_pkg::OP_LDA) ||
                       (h_op == sicxe_pkg::OP_LDB) || (h_op == sicxe_pkg::OP_LDT);

    logic [23:0] h_val;
    assign h_val = h_imm ? 24'(r_ta) : r_buf[23:0];

    // memory port
    always_comb begin
        mem_re    = (r_state == S_READ) && (r_rcnt < r_rlen);
        mem_raddr = r_rbase + ADDR_BITS'(r_rcnt);
        if (r_state == S_STORE) begin
            mem_we    = 1'b1;
            mem_waddr = r_ea + ADDR_BITS'(r_wcnt);
            mem_wdata = r_wdata[23:16];
        end else begin
            mem_we    = req_fire && (i_req.mode == sicxe_pkg::MODE_WR_MEM);
            mem_waddr = i_req.address[ADDR_BITS-1:0];
            mem_wdata = i_req.data[7:0];
        end
    end

    logic [2:0] got_now;
    assign got_now = r_rgot + {2'b00, r_rpend};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_FETCH;
            r_a <= '0; r_x <= '0; r_l <= '0; r_b <= '0; r_s <= '0; r_t <= '0;
            r_pc        <= '0;
            r_cc        <= sicxe_pkg::CC_EQ;
            r_start     <= '0;
            r_len       <= 21'h100000;
            r_rpend     <= 1'b0;
            r_out_valid <= 1'b0;
            r_bad       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == sicxe_pkg::CFG_PROG_START) begin
                    r_start <= i_cfg.data[19:0];
                end else begin
                    r_len <= i_cfg.data;
                end
            end
            if (rsp_fire) begin
                r_out_valid <= 1'b0;
            end
            r_rpend <= mem_re;
            if (r_rpend) begin
                r_buf  <= {r_buf[23:0], mem_rdata};
                r_rgot <= got_now;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_bad <= 1'b0;
                    if (req_fire) begin
                        r_state <= S_FIN;
                        if (i_req.mode == sicxe_pkg::MODE_WR_REG) begin
                            priority case ({1'b0, i_req.reg_select})
                                sicxe_pkg::REG_A:  r_a  <= i_req.data;
                                sicxe_pkg::REG_X:  r_x  <= i_req.data;
                                sicxe_pkg::REG_L:  r_l  <= i_req.data;
                                sicxe_pkg::REG_B:  r_b  <= i_req.data;
                                sicxe_pkg::REG_S:  r_s  <= i_req.data;
                                sicxe_pkg::REG_T:  r_t  <= i_req.data;
                                sicxe_pkg::REG_PC: r_pc <= i_req.data[ADDR_BITS-1:0];
                                default: ;
                            endcase
                        end else if (i_req.mode == sicxe_pkg::MODE_EXEC && !at_end) begin
                            // fetch four bytes at PC
                            r_state <= S_READ;
                            r_phase <= P_FETCH;
                            r_rbase <= r_pc;
                            r_rcnt  <= '0;
                            r_rgot  <= '0;
                            r_rlen  <= 3'd4;
                        end
                    end
                end

                S_READ: begin
                    if (mem_re) begin
                        r_rcnt <= r_rcnt + 3'd1;
                    end
                    if (r_rpend && got_now == r_rlen) begin
                        unique case (r_phase)
                            P_FETCH: r_state <= S_DECODE;
                            P_IND:   r_state <= S_ADDR;
                            P_OPND:  r_state <= S_EXEC;
                            default: r_state <= S_EXEC;
                        endcase
                    end
                end

                S_DECODE: begin
                    r_ins   <= r_buf;
                    r_ta    <= d_ta;
                    r_next  <= r_pc + (r_buf[20] ? ADDR_BITS'(4) : ADDR_BITS'(3));
                    r_state <= S_FIN;
                    if (d_op == sicxe_pkg::OP_CLEAR) begin
                        priority case (d_r1)
                            sicxe_pkg::REG_A: r_a <= '0;
                            sicxe_pkg::REG_X: r_x <= '0;
                            sicxe_pkg::REG_L: r_l <= '0;
                            sicxe_pkg::REG_B: r_b <= '0;
                            sicxe_pkg::REG_S: r_s <= '0;
                            sicxe_pkg::REG_T: r_t <= '0;
                            default: ;
                        endcase
                        r_pc <= r_pc + ADDR_BITS'(2);
                    end else if (d_op == sicxe_pkg::OP_COMPR) begin
                        r_cc <= sicxe_pkg::compare(d_r1v, d_r2v);
                        r_pc <= r_pc + ADDR_BITS'(2);
                    end else if (d_op == sicxe_pkg::OP_TIXR) begin
                        // compare against the incremented X, also when r1 names X
                        r_x  <= d_xinc;
                        r_cc <= sicxe_pkg::compare(d_xinc,
                                    (d_r1 == sicxe_pkg::REG_X) ? d_xinc : d_r1v);
                        r_pc <= r_pc + ADDR_BITS'(2);
                    end else if (!sicxe_pkg::is_fmt3_op(d_op)) begin
                        r_bad <= 1'b1;
                    end else if (r_buf[25] && !r_buf[24]) begin
                        // indirect: fetch the address word at the target
                        r_state <= S_READ;
                        r_phase <= P_IND;
                        r_rbase <= d_ta;
                        r_rcnt  <= '0;
                        r_rgot  <= '0;
                        r_rlen  <= 3'd3;
                    end else begin
                        r_state <= S_ADDR;
                    end
                end

                S_ADDR: begin
                    r_ea    <= h_ea;
                    r_state <= S_EXEC;
                    if (!h_imm && (h_word_ld || h_op == sicxe_pkg::OP_LDCH)) begin
                        r_state <= S_READ;
                        r_phase <= P_OPND;
                        r_rbase <= h_ea;
                        r_rcnt  <= '0;
                        r_rgot  <= '0;
                        r_rlen  <= (h_op == sicxe_pkg::OP_LDCH) ? 3'd1 : 3'd3;
                    end
                end

                S_EXEC: begin
                    r_state <= S_FIN;
                    r_pc    <= r_next;
                    r_wcnt  <= '0;
                    r_wlast <= 2'd2;
                    priority case (h_op)
                        sicxe_pkg::OP_COMP: r_cc <= sicxe_pkg::compare(r_a, h_val);
                        sicxe_pkg::OP_J:    r_pc <= r_ea;
                        sicxe_pkg::OP_JEQ:  if (r_cc == sicxe_pkg::CC_EQ) r_pc <= r_ea;
                        sicxe_pkg::OP_JLT:  if (r_cc == sicxe_pkg::CC_LT) r_pc <= r_ea;
                        sicxe_pkg::OP_JSUB: begin
                            r_l  <= 24'(r_next);
                            r_pc <= r_ea;
                        end
                        sicxe_pkg::OP_RSUB: r_pc <= r_l[ADDR_BITS-1:0];
                        sicxe_pkg::OP_LDA:  r_a  <= h_val;
                        sicxe_pkg::OP_LDB:  r_b  <= h_val;
                        sicxe_pkg::OP_LDT:  r_t  <= h_val;
                        sicxe_pkg::OP_LDCH: r_a  <= {r_a[23:8], h_val[7:0]};
                        sicxe_pkg::OP_STA: begin
                            r_wdata <= r_a;
                            r_state <= S_STORE;
                            r_pc    <= r_pc;
                        end
                        sicxe_pkg::OP_STL: begin
                            r_wdata <= r_l;
                            r_state <= S_STORE;
                            r_pc    <= r_pc;
                        end
                        sicxe_pkg::OP_STX: begin
                            r_wdata <= r_x;
                            r_state <= S_STORE;
                            r_pc    <= r_pc;
                        end
                        sicxe_pkg::OP_STCH: begin
                            r_wdata <= {r_a[7:0], 16'h0000};
                            r_wlast <= 2'd0;
                            r_state <= S_STORE;
                            r_pc    <= r_pc;
                        end
                        sicxe_pkg::OP_TD:   r_cc <= sicxe_pkg::CC_LT;
                        default: ;
                    endcase
                end

                S_STORE: begin
                    // one byte a cycle, most significant first
                    r_wdata <= {r_wdata[15:0], 8'h00};
                    r_wcnt  <= r_wcnt + 2'd1;
                    if (r_wcnt == r_wlast) begin
                        r_pc    <= r_next;
                        r_state <= S_FIN;
                    end
                end

                S_FIN: begin
                    // hold until the response register is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out.pc        <= 20'(r_pc);
                        r_out.acc       <= r_a;
                        r_out.index_reg <= r_x;
                        r_out.link_reg  <= r_l;
                        r_out.base_reg  <= r_b;
                        r_out.s_reg     <= r_s;
                        r_out.t_reg     <= r_t;
                        r_out.cond      <= r_cc;
                        r_out.halted    <= at_end;
                        r_out.illegal   <= r_bad;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.pc        = r_out.pc;
    assign o_rsp.acc       = r_out.acc;
    assign o_rsp.index_reg = r_out.index_reg;
    assign o_rsp.link_reg  = r_out.link_reg;
    assign o_rsp.base_reg  = r_out.base_reg;
    assign o_rsp.s_reg     = r_out.s_reg;
    assign o_rsp.t_reg     = r_out.t_reg;
    assign o_rsp.cond      = r_out.cond;
    assign o_rsp.halted    = r_out.halted;
    assign o_rsp.illegal   = r_out.illegal;
endmodule
`default_nettype wire

[hw/rtl/sicxe_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sicxe_mem
// Byte-wide main memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module sicxe_mem #(
    parameter int ADDR_BITS = sicxe_pkg::ADDR_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [7:0]           i_wdata,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [7:0]           o_rdata
);
    logic [7:0] r_mem [2**ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[bench/sicxe_step_checker.sv]
// ----------------------------------------------------------------------------
// sicxe_step_checker
// Watches the request, response and configuration channels, keeps a shadow of
// the machine state, predicts the state after every request and compares each
// response with the oldest prediction.
// ----------------------------------------------------------------------------
module sicxe_step_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sicxe_req_if        req,
    sicxe_rsp_if        rsp,
    sicxe_cfg_if        cfg,
    output int          o_fail_count,
    output int          o_pending
);

    bit   [7:0]  mem_image [bit [19:0]];
    logic [23:0] gpr [6];
    logic [19:0] pc_now;
    logic [1:0]  cc_now;
    logic [19:0] start_now;
    logic [20:0] length_now;
    sicxe_pkg::t_rsp state_after_step_q[$];
    int          fail_count;
    int          pending;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic logic [1:0] rank(input logic [23:0] a, input logic [23:0] b);
        if (a == b) return sicxe_pkg::CC_EQ;
        return (a < b) ? sicxe_pkg::CC_LT : sicxe_pkg::CC_GT;
    endfunction

    function automatic logic [23:0] reg_or_zero(input logic [3:0] r);
        return (r < 4'd6) ? gpr[r[2:0]] : 24'd0;
    endfunction

    // every byte read is logged, so the stimulus can fill gaps before a step
    function automatic logic [7:0] peek(input logic [19:0] a, ref logic [19:0] trail[$]);
        trail.push_back(a);
        return mem_image.exists(a) ? mem_image[a] : 8'h00;
    endfunction

    function automatic logic [23:0] peek_word(input logic [19:0] a,
                                              ref logic [19:0] trail[$]);
        logic [7:0] hi, mid, lo;
        hi  = peek(a, trail);
        mid = peek(a + 20'd1, trail);
        lo  = peek(a + 20'd2, trail);
        return {hi, mid, lo};
    endfunction

    function automatic void poke_word(input logic [19:0] a, input logic [23:0] v);
        mem_image[a]         = v[23:16];
        mem_image[a + 20'd1] = v[15:8];
        mem_image[a + 20'd2] = v[7:0];
    endfunction

    function automatic logic past_end();
        return 22'(pc_now) >= 22'(start_now) + 22'(length_now);
    endfunction

    // Decode and, when apply is set, execute the instruction at PC.
    // Returns 1 for an unsupported opcode when apply is set.
    function automatic logic execute_instr(input logic apply, ref logic [19:0] trail[$]);
        logic [19:0] pc, ta, ea, nxt;
        logic [7:0]  b0, b1, b2, b3, op;
        logic [11:0] disp;
        logic [31:0] ta32;
        logic [23:0] ind, val;
        logic        imm;
        pc = pc_now;
        b0 = peek(pc, trail);
        b1 = peek(pc + 20'd1, trail);
        b2 = peek(pc + 20'd2, trail);
        b3 = peek(pc + 20'd3, trail);
        op = b0 & 8'hFC;
        if (op == sicxe_pkg::OP_CLEAR || op == sicxe_pkg::OP_COMPR ||
            op == sicxe_pkg::OP_TIXR) begin
            if (apply) begin
                case (op)
                    sicxe_pkg::OP_CLEAR: if (b1[7:4] < 4'd6) gpr[b1[6:4]] = 24'd0;
                    sicxe_pkg::OP_COMPR:
                        cc_now = rank(reg_or_zero(b1[7:4]), reg_or_zero(b1[3:0]));
                    default: begin
                        gpr[1] = gpr[1] + 24'd1;
                        cc_now = rank(gpr[1], reg_or_zero(b1[7:4]));
                    end
                endcase
                pc_now = pc + 20'd2;
            end
            return 1'b0;
        end
        disp = {b1[3:0], b2};
        if (b1[4]) begin
            ta32 = {12'd0, b1[3:0], b2, b3} + 32'(start_now);
        end else if (b1[6]) begin
            ta32 = 32'(gpr[3]) + 32'(disp);
        end else if (b1[5]) begin
            ta32 = 32'(pc) + 32'd3 + {{20{disp[11]}}, disp};
        end else begin
            ta32 = 32'(disp);
        end
        if (b1[7]) ta32 = ta32 + 32'(gpr[1]);
        ta  = ta32[19:0];
        nxt = pc + (b1[4] ? 20'd4 : 20'd3);
        imm = !b0[1];
        ea  = ta;
        if (b0[1] && !b0[0]) begin
            ind = peek_word(ta, trail);
            ea  = ind[19:0];
        end
        val = imm ? 24'(ta) : peek_word(ea, trail);
        if (!apply) return 1'b0;
        case (op)
            sicxe_pkg::OP_COMP: cc_now = rank(gpr[0], val);
            sicxe_pkg::OP_J:    nxt = ea;
            sicxe_pkg::OP_JEQ:  if (cc_now == sicxe_pkg::CC_EQ) nxt = ea;
            sicxe_pkg::OP_JLT:  if (cc_now == sicxe_pkg::CC_LT) nxt = ea;
            sicxe_pkg::OP_JSUB: begin
                gpr[2] = 24'(nxt);
                nxt    = ea;
            end
            sicxe_pkg::OP_RSUB: nxt = gpr[2][19:0];
            sicxe_pkg::OP_LDA:  gpr[0] = val;
            sicxe_pkg::OP_LDB:  gpr[3] = val;
            sicxe_pkg::OP_LDT:  gpr[5] = val;
            sicxe_pkg::OP_LDCH: gpr[0][7:0] = imm ? ta[7:0] : peek(ea, trail);
            sicxe_pkg::OP_STA:  poke_word(ea, gpr[0]);
            sicxe_pkg::OP_STCH: mem_image[ea] = gpr[0][7:0];
            sicxe_pkg::OP_STL:  poke_word(ea, gpr[2]);
            sicxe_pkg::OP_STX:  poke_word(ea, gpr[1]);
            sicxe_pkg::OP_RD, sicxe_pkg::OP_WD: ;
            sicxe_pkg::OP_TD:   cc_now = sicxe_pkg::CC_LT;
            default: return 1'b1;
        endcase
        pc_now = nxt;
        return 1'b0;
    endfunction

    // first byte the next execute step would read without it ever being written
    function automatic logic find_unread_gap(output logic [19:0] a);
        logic [19:0] trail[$];
        a = '0;
        if (past_end()) return 1'b0;
        void'(execute_instr(1'b0, trail));
        foreach (trail[k]) begin
            if (!mem_image.exists(trail[k])) begin
                a = trail[k];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic sicxe_pkg::t_rsp predict_step(input logic [1:0] m,
                                                     input logic [19:0] a,
                                                     input logic [23:0] d,
                                                     input logic [2:0] s);
        sicxe_pkg::t_rsp r;
        logic        bad;
        logic [19:0] trail[$];
        bad = 1'b0;
        case (m)
            sicxe_pkg::MODE_WR_MEM: mem_image[a] = d[7:0];
            sicxe_pkg::MODE_WR_REG: begin
                if ({1'b0, s} < sicxe_pkg::REG_PC) gpr[s] = d;
                else if ({1'b0, s} == sicxe_pkg::REG_PC) pc_now = d[19:0];
            end
            sicxe_pkg::MODE_EXEC: if (!past_end()) bad = execute_instr(1'b1, trail);
            default: ;
        endcase
        r.pc        = pc_now;
        r.acc       = gpr[0];
        r.index_reg = gpr[1];
        r.link_reg  = gpr[2];
        r.base_reg  = gpr[3];
        r.s_reg     = gpr[4];
        r.t_reg     = gpr[5];
        r.cond      = cc_now;
        r.halted    = past_end();
        r.illegal   = bad;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge i_clk) begin
        sicxe_pkg::t_rsp want;
        if (!i_rst_n) begin
            foreach (gpr[k]) gpr[k] = '0;
            pc_now     = '0;
            cc_now     = sicxe_pkg::CC_EQ;
            start_now  = '0;
            length_now = 21'h100000;
            state_after_step_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == sicxe_pkg::CFG_PROG_START) start_now = cfg.data[19:0];
                else length_now = cfg.data;
            end
            if (req.valid && req.ready)
                state_after_step_q.push_back(predict_step(req.mode, req.address, req.data,
                                                          req.reg_select));
            if (rsp.valid && rsp.ready) begin
                if (state_after_step_q.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = state_after_step_q.pop_front();
                    check_field("pc", 24'(rsp.pc), 24'(want.pc));
                    check_field("acc", rsp.acc, want.acc);
                    check_field("index_reg", rsp.index_reg, want.index_reg);
                    check_field("link_reg", rsp.link_reg, want.link_reg);
                    check_field("base_reg", rsp.base_reg, want.base_reg);
                    check_field("s_reg", rsp.s_reg, want.s_reg);
                    check_field("t_reg", rsp.t_reg, want.t_reg);
                    check_field("cond", 24'(rsp.cond), 24'(want.cond));
                    check_field("halted", 24'(rsp.halted), 24'(want.halted));
                    check_field("illegal", 24'(rsp.illegal), 24'(want.illegal));
                end
            end
        end
        pending = state_after_step_q.size();
    end

endmodule

[bench/sicxe_instruction_step_tb.sv]
// ----------------------------------------------------------------------------
// sicxe_instruction_step_tb
// Drives memory writes, register writes, the unused mode and instruction steps into the SIC/XE
// step block under several program windows, with random gaps and stalls on
// both sides, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module sicxe_instruction_step_tb;

    localparam logic [7:0] KNOWN_OPS [20] = '{
        sicxe_pkg::OP_CLEAR, sicxe_pkg::OP_COMPR, sicxe_pkg::OP_TIXR,
        sicxe_pkg::OP_COMP, sicxe_pkg::OP_J, sicxe_pkg::OP_JEQ, sicxe_pkg::OP_JLT,
        sicxe_pkg::OP_JSUB, sicxe_pkg::OP_RSUB, sicxe_pkg::OP_LDA, sicxe_pkg::OP_LDB,
        sicxe_pkg::OP_LDT, sicxe_pkg::OP_LDCH, sicxe_pkg::OP_STA, sicxe_pkg::OP_STCH,
        sicxe_pkg::OP_STL, sicxe_pkg::OP_STX, sicxe_pkg::OP_RD, sicxe_pkg::OP_WD,
        sicxe_pkg::OP_TD
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   sent;
    bit   calm;
    bit   long_hold_done;

    always #5 i_clk = ~i_clk;

    sicxe_req_if req ();
    sicxe_rsp_if rsp ();
    sicxe_cfg_if cfg ();

    sicxe_instruction_step dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .i_cfg   (cfg)
    );

    sicxe_step_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req),
        .rsp          (rsp),
        .cfg          (cfg),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one request after a random gap and hold it until it is taken.
    // Returns just after a falling edge, so the checker has already absorbed
    // the request and its shadow state can steer the next one.
    task automatic send(input logic [1:0] m, input logic [19:0] a,
                        input logic [23:0] d, input logic [2:0] s);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        repeat (gap) @(posedge i_clk);
        @(posedge i_clk);
        req.valid      <= 1'b1;
        req.mode       <= m;
        req.address    <= a;
        req.data       <= d;
        req.reg_select <= s;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        req.valid <= 1'b0;
        sent++;
        @(negedge i_clk);
    endtask

    task automatic put_byte(input logic [19:0] a, input logic [7:0] v);
        logic [23:0] d;
        d = 24'($urandom);
        send(sicxe_pkg::MODE_WR_MEM, a, {d[23:8], v}, 3'($urandom));
    endtask

    // Write a register only while the block is idle: drain every outstanding
    // response first, then let the pipeline settle.
    task automatic write_cfg(input logic idx, input logic [20:0] value);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_opcode();
        logic [7:0] b;
        if ($urandom_range(0, 21) < 20) return KNOWN_OPS[5'($urandom_range(0, 19))];
        // unsupported opcode: anything outside the known set
        do begin
            b = 8'($urandom) & 8'hFC;
        end while (sicxe_pkg::is_fmt3_op(b) || b == sicxe_pkg::OP_CLEAR ||
                   b == sicxe_pkg::OP_COMPR || b == sicxe_pkg::OP_TIXR);
        return b;
    endfunction

    // Optionally lay a fresh instruction at PC, fill every byte the step would
    // read that was never written, then execute.
    task automatic run_instr(input logic [7:0] op, input bit lay);
        logic [19:0] pc, gap_addr;
        logic [7:0]  b1;
        pc = chk.pc_now;
        if (lay) begin
            b1 = 8'($urandom);
            if (op == sicxe_pkg::OP_CLEAR || op == sicxe_pkg::OP_COMPR ||
                op == sicxe_pkg::OP_TIXR) begin
                put_byte(pc, op);
                put_byte(pc + 20'd1, b1);
            end else begin
                put_byte(pc, op | 8'($urandom_range(0, 3)));
                put_byte(pc + 20'd1, b1);
                put_byte(pc + 20'd2, 8'($urandom));
                if (b1[4]) put_byte(pc + 20'd3, 8'($urandom));
            end
        end
        while (chk.find_unread_gap(gap_addr)) put_byte(gap_addr, 8'($urandom));
        send(sicxe_pkg::MODE_EXEC, 20'($urandom), 24'($urandom), 3'($urandom));
    endtask

    // random traffic until about budget more requests have gone in
    task automatic random_phase(input int budget);
        int          r;
        int          stop;
        logic [2:0]  s;
        logic [23:0] d;
        stop = sent + budget;
        while (sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 9) begin
                s = 3'($urandom_range(0, 7));
                d = 24'($urandom);
                // keep PC near the program window most of the time
                if ({1'b0, s} == sicxe_pkg::REG_PC && $urandom_range(0, 9) < 6)
                    d = 24'(chk.start_now + 20'($urandom_range(0, 96)));
                send(sicxe_pkg::MODE_WR_REG, 20'($urandom), d, s);
            end else if (r < 14) begin
                send(sicxe_pkg::MODE_WR_MEM, 20'($urandom), 24'($urandom), 3'($urandom));
            end else if (r < 17) begin
                send(2'd3, 20'($urandom), 24'($urandom), 3'($urandom));
            end else begin
                run_instr(pick_opcode(), $urandom_range(0, 99) < 65);
            end
        end
    endtask

    // response side: random stall per response, one long hold-off mid-run
    initial begin
        int stall;
        rsp.ready      <= 1'b0;
        long_hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 18);
            if (!long_hold_done && sent >= 500) begin
                long_hold_done = 1'b1;
                stall          = 400;
            end
            if (stall > 0) begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp.valid) @(posedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin
        logic [20:0] starts [5];
        logic [20:0] lengths [5];
        sent           = 0;
        calm           = 1'b0;
        req.valid      <= 1'b0;
        req.mode       <= sicxe_pkg::MODE_WR_MEM;
        req.address    <= '0;
        req.data       <= '0;
        req.reg_select <= '0;
        cfg.valid      <= 1'b0;
        cfg.index      <= sicxe_pkg::CFG_PROG_START;
        cfg.data       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, every register select, unused mode, an unknown opcode
        write_cfg(sicxe_pkg::CFG_PROG_START, 21'd0);
        write_cfg(sicxe_pkg::CFG_PROG_LENGTH, 21'h100000);
        for (int k = 0; k < 8; k++)
            send(sicxe_pkg::MODE_WR_REG, 20'hFFFFF, (k % 2) ? 24'hFFFFFF : 24'h000000,
                 3'(k));
        send(sicxe_pkg::MODE_WR_MEM, 20'h00000, 24'h000000, 3'd0);
        send(2'd3, 20'hFFFFF, 24'hFFFFFF, 3'd7);
        run_instr(sicxe_pkg::OP_LDA, 1'b1);
        run_instr(8'hFC, 1'b1);
        run_instr(sicxe_pkg::OP_TIXR, 1'b1);
        run_instr(sicxe_pkg::OP_TD, 1'b1);
        run_instr(sicxe_pkg::OP_RSUB, 1'b1);

        // program windows: full memory, empty, small, top of memory, random
        starts  = '{21'd0, 21'h0FFFFF, 21'h000200, 21'h0FFFFF, 21'($urandom)};
        lengths = '{21'h100000, 21'd0, 21'h000080, 21'h100000,
                    21'($urandom_range(0, 21'h100000))};
        for (int ph = 0; ph < 5; ph++) begin
            write_cfg(sicxe_pkg::CFG_PROG_START, starts[ph]);
            write_cfg(sicxe_pkg::CFG_PROG_LENGTH, lengths[ph]);
            calm = (ph == 2);
            random_phase(250);
            // hold the sender until every response is back
            while (pending != 0) @(negedge i_clk);
        end

        calm = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40000000;
        $display("status: fail");
        $finish;
    end

endmodule

[sicxe_instruction_step.f]
hw/rtl/sicxe_pkg.sv
hw/rtl/sicxe_if.sv
hw/rtl/sicxe_mem.sv
hw/rtl/sicxe_instruction_step.sv
bench/sicxe_step_checker.sv
bench/sicxe_instruction_step_tb.sv
